### src/usbmba_pkg.sv
`default_nettype none

package usbmba_pkg;

  // Default sizes of the endpoint record store and the usage counters.
  localparam int NumEndpointsDef = 32;
  localparam int UsageWidthDef   = 16;

  // Request codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] KIND_INT = 2'd0;
  localparam logic [1:0] KIND_ISO = 2'd1;

  localparam logic [1:0] SPEED_LOW  = 2'd0;
  localparam logic [1:0] SPEED_FULL = 2'd1;

  localparam logic STATUS_OK           = 1'b0;
  localparam logic STATUS_FREE_AT_ZERO = 1'b1;

  // Isochronous interval codes.
  localparam logic [1:0] SHIFT_EVERY = 2'd0;
  localparam logic [1:0] SHIFT_HALF  = 2'd1;
  localparam logic [1:0] SHIFT_QUART = 2'd2;

  // Microframe masks.
  localparam logic [7:0] MASK_ONE   = 8'h01;
  localparam logic [7:0] MASK_ALL   = 8'hFF;
  localparam logic [7:0] MASK_HALF  = 8'h55;
  localparam logic [7:0] MASK_QUART = 8'h11;

  // Complete-split mask terms.
  localparam logic [7:0] CMASK_BASE = 8'h04;
  localparam logic [7:0] CMASK_KEEP = 8'hFE;

  localparam logic [7:0] REFS_MAX = 8'hFF;

  // Slot search windows, given as first and last microframe.
  localparam logic [2:0] SPLIT_FIRST = 3'd4;
  localparam logic [2:0] SPLIT_LAST  = 3'd5;
  localparam logic [2:0] HS_FIRST    = 3'd0;
  localparam logic [2:0] HS_LAST     = 3'd7;

  localparam logic [2:0] UFRAME_LAST = 3'd7;

  // One endpoint record.
  typedef struct packed {
    logic [7:0] refs;
    logic [2:0] slot;
    logic [7:0] smask;
  } ep_rec_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOOKUP = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_SEARCH = 7'b0001000,
    S_CHARGE = 7'b0010000,
    S_WRITE  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  // Allocation mask for an endpoint of the given kind and interval.
  function automatic logic [7:0] alloc_mask(input logic [1:0] kind, input logic [1:0] shift);
    logic [7:0] m;
    m = MASK_ONE;
    if (kind == KIND_ISO) begin
      case (shift)
        SHIFT_EVERY: m = MASK_ALL;
        SHIFT_HALF:  m = MASK_HALF;
        SHIFT_QUART: m = MASK_QUART;
        default:     m = MASK_ONE;
      endcase
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### src/usb_microframe_bandwidth_allocator_top.sv
// Flow: an accepted item is looked up in the record store and decided, then searched and
// charged where needed, and written; an index outside the record store goes straight to the
// result. High-speed first allocations walk up to 36 steps of the shared slot-search adder, plus up to 8 charge steps.
// Throughput: one item at a time; the next item is taken after the result has been taken.
// Reset (rst, synchronous, active high) clears both usage tables and all endpoint
// record valid bits at once; a record that was never written reads as all zero.
`default_nettype none

module usb_microframe_bandwidth_allocator_top #(
  parameter int NUM_ENDPOINTS = usbmba_pkg::NumEndpointsDef,
  parameter int USAGE_WIDTH   = usbmba_pkg::UsageWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [4:0]  endpoint_index,
  input  wire logic [1:0]  transfer_kind,
  input  wire logic [1:0]  device_speed,
  input  wire logic [1:0]  interval_code,
  input  wire logic [15:0] transfer_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       start_slot,
  output logic [7:0]       start_mask,
  output logic [7:0]       complete_mask,
  output logic             tables_changed,
  output logic             status
);
  import usbmba_pkg::*;

  localparam int EpAw = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;

  typedef logic [USAGE_WIDTH-1:0] usage_t;

  state_t state, state_next;

  // Registered request.
  logic       req_func;
  logic [4:0] req_ep;
  logic [1:0] req_kind;
  logic [1:0] req_speed;
  logic [1:0] req_shift;
  logic [15:0] req_len;

  // Endpoint record store.
  ep_rec_t                 rec_mem [NUM_ENDPOINTS];
  logic [NUM_ENDPOINTS-1:0] rec_valid;
  ep_rec_t                 rd_data;
  logic                    rd_valid;
  ep_rec_t                 rec;
  logic [EpAw-1:0]         ep_addr;
  logic                    ep_in_range;

  // Usage tables.
  usage_t hub_usage  [8];
  usage_t ctrl_usage [8];

  // Working registers of the search and charge steps.
  logic [7:0] wr_refs;
  logic [2:0] wr_slot;
  logic [7:0] wr_smask;
  logic [7:0] ch_mask;
  logic [2:0] ch_slot;
  usage_t     ch_len;
  logic [2:0] cs;
  logic [2:0] bw;
  logic [2:0] srch_last;
  logic [2:0] idx;
  usage_t     sum;
  usage_t     best;
  logic [2:0] chosen;

  logic   req_split;
  logic   req_periodic;
  logic   dec_search;
  logic   dec_charge;
  usage_t len_base;
  usage_t len_scaled;
  usage_t tab_word;
  usage_t term;
  usage_t sum_new;
  logic [2:0] off;
  logic [2:0] off_last;
  logic   row_end;
  logic   take;
  logic   stop;
  logic [2:0] chosen_new;
  logic [2:0] ch_off;
  logic   ch_hit;

  assign in_stall  = rst || (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  assign ep_addr     = EpAw'(req_ep);
  assign ep_in_range = (int'(req_ep) < NUM_ENDPOINTS);
  assign rec         = rd_valid ? rd_data : '0;

  assign req_split    = (req_speed == SPEED_LOW) || (req_speed == SPEED_FULL);
  assign req_periodic = (req_kind == KIND_INT) || (req_kind == KIND_ISO);

  // Charge amount: low speed costs eight times, a free subtracts.
  always_comb begin
    len_base   = USAGE_WIDTH'(req_len);
    len_scaled = (req_speed == SPEED_LOW) ? (len_base << 3) : len_base;
  end

  // Which path the request takes once its record is known.
  always_comb begin
    dec_search = 1'b0;
    dec_charge = 1'b0;
    if (req_func == FUNC_ALLOC) begin
      dec_search = (rec.refs == 8'd0) && req_periodic;
    end else begin
      dec_charge = (rec.refs == 8'd1) && req_periodic;
    end
  end

  // Slot search step: one masked add per cycle, compare at the end of a row.
  always_comb begin
    tab_word   = req_split ? hub_usage[bw] : ctrl_usage[bw];
    off        = bw - cs;
    term       = ch_mask[off] ? tab_word : '0;
    sum_new    = sum + term;
    row_end    = (bw == srch_last);
    take       = row_end && (best >= sum_new);
    chosen_new = take ? cs : chosen;
    off_last   = srch_last - cs;
    stop       = row_end && (ch_mask[off_last] || (cs == srch_last));
  end

  // Charge step: one microframe per cycle from the slot upward.
  assign ch_off = idx - ch_slot;
  assign ch_hit = ch_mask[ch_off];

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_next = ep_in_range ? S_DECIDE : S_OUT;
      end
      S_DECIDE: begin
        if (dec_search) begin
          state_next = S_SEARCH;
        end else if (dec_charge) begin
          state_next = S_CHARGE;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_SEARCH: begin
        if (stop) begin
          state_next = S_CHARGE;
        end
      end
      S_CHARGE: begin
        if (idx == UFRAME_LAST) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Record store: registered read, written at most once per item (not for an index outside it).
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      rec_mem[ep_addr] <= '{refs: wr_refs, slot: wr_slot, smask: wr_smask};
    end
    rd_data <= rec_mem[ep_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= rec_valid[ep_addr];
      if (state == S_WRITE) begin
        rec_valid[ep_addr] <= 1'b1;
      end
    end
  end

  // Usage tables change only during the charge steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        hub_usage[i]  <= '0;
        ctrl_usage[i] <= '0;
      end
    end else if ((state == S_CHARGE) && ch_hit) begin
      ctrl_usage[idx] <= ctrl_usage[idx] + ch_len;
      if (req_split) begin
        hub_usage[idx] <= hub_usage[idx] + ch_len;
      end
    end
  end

  // Request capture, decision, search and result registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        req_func  <= func;
        req_ep    <= endpoint_index;
        req_kind  <= transfer_kind;
        req_speed <= device_speed;
        req_shift <= interval_code;
        req_len   <= transfer_length;
      end
      S_LOOKUP: begin
        start_slot     <= 3'd0;
        start_mask     <= 8'd0;
        complete_mask  <= 8'd0;
        tables_changed <= 1'b0;
        status         <= STATUS_OK;
      end
      S_DECIDE: begin
        wr_refs        <= rec.refs;
        wr_slot        <= rec.slot;
        wr_smask       <= rec.smask;
        tables_changed <= 1'b0;
        status         <= STATUS_OK;
        cs             <= req_split ? SPLIT_FIRST : HS_FIRST;
        bw             <= req_split ? SPLIT_FIRST : HS_FIRST;
        srch_last      <= req_split ? SPLIT_LAST : HS_LAST;
        sum            <= '0;
        best           <= '1;
        chosen         <= 3'd0;
        ch_len         <= (req_func == FUNC_FREE) ? (usage_t'(0) - len_scaled) : len_scaled;
        ch_mask        <= alloc_mask(req_kind, req_shift);
        ch_slot        <= rec.slot;
        idx            <= rec.slot;
        if (req_func == FUNC_ALLOC) begin
          if (rec.refs != REFS_MAX) begin
            wr_refs <= rec.refs + 8'd1;
            if (rec.refs == 8'd0) begin
              wr_slot  <= 3'd0;
              wr_smask <= 8'd0;
              tables_changed <= req_periodic;
            end
          end
        end else begin
          if (rec.refs == 8'd0) begin
            status <= STATUS_FREE_AT_ZERO;
          end else begin
            wr_refs <= rec.refs - 8'd1;
            if (dec_charge) begin
              ch_mask        <= rec.smask >> rec.slot;
              wr_slot        <= 3'd0;
              wr_smask       <= 8'd0;
              tables_changed <= 1'b1;
            end
          end
        end
      end
      S_SEARCH: begin
        if (row_end) begin
          if (take) begin
            best   <= sum_new;
            chosen <= cs;
          end
          if (stop) begin
            ch_slot  <= chosen_new;
            idx      <= chosen_new;
            wr_slot  <= chosen_new;
            wr_smask <= ch_mask << chosen_new;
          end else begin
            cs  <= cs + 3'd1;
            bw  <= cs + 3'd1;
            sum <= '0;
          end
        end else begin
          bw  <= bw + 3'd1;
          sum <= sum_new;
        end
      end
      S_CHARGE: begin
        idx <= idx + 3'd1;
      end
      S_WRITE: begin
        start_slot <= wr_slot;
        start_mask <= wr_smask;
        if ((wr_refs != 8'd0) && (req_kind == KIND_INT) && req_split) begin
          complete_mask <= (8'd0 - (CMASK_BASE << wr_slot)) & CMASK_KEEP;
        end else begin
          complete_mask <= 8'd0;
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
